/* hdl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants for the frame bitmap allocator
// Request/result payloads, queue entry, engine control and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

  localparam int BITMAP_WORDS_DEF  = 32768;
  localparam int FRAME_SHIFT       = 12;
  localparam int ADDR_W            = 32;
  localparam int FRAME_W           = 20;
  localparam int BIT_W             = 5;
  localparam int WORD_W            = FRAME_W - BIT_W;
  localparam int CFG_W             = 21;
  localparam int DATA_W            = 32;
  // search skips the first MiB: frame 0x100 is word 8
  localparam int SEARCH_START_WORD = 'h100 >> BIT_W;

  typedef enum logic [1:0] {
    CMD_MARK = 2'd0,
    CMD_FREE = 2'd1,
    CMD_TEST = 2'd2,
    CMD_FIND = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] frame_address;
  } req_t;

  typedef struct packed {
    logic               frame_in_use;
    logic [FRAME_W-1:0] found_frame;
    logic               none_free;
  } result_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] word;
    logic [BIT_W-1:0]  bit_sel;
    logic              in_range;
  } q_entry_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } eng_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN
  } state_t;

  // index of the lowest clear bit; caller guarantees w is not all ones
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [DATA_W-1:0] w);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        n = BIT_W'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* hdl/fba_ram.sv */
// ----------------------------------------------------------------------------
// fba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/fba_front.sv */
// ----------------------------------------------------------------------------
// fba_front: request decode and queue
// Splits the address into word and bit, range-checks the word and holds
// decoded requests in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_front
  import fba_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire req_t     request,
  input  wire eng_ctl_t ctl,
  output logic          busy,
  output logic          q_valid,
  output q_entry_t      q_head
);

  q_entry_t            slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;
  logic                pop;
  q_entry_t            decoded;
  logic [FRAME_W-1:0]  frame;

  assign frame = request.frame_address[ADDR_W-1:FRAME_SHIFT];

  always_comb begin
    decoded.cmd      = cmd_t'(request.command);
    decoded.word     = frame[FRAME_W-1:BIT_W];
    decoded.bit_sel  = frame[BIT_W-1:0];
    decoded.in_range = ({1'b0, frame[FRAME_W-1:BIT_W]} < (WORD_W+1)'(BITMAP_WORDS));
  end

  assign busy    = ctl.clearing || (count == 2'd2);
  assign push    = start && !busy;
  assign pop     = ctl.pop && (count != 2'd0);
  assign q_valid = (count != 2'd0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/fba_engine.sv */
// ----------------------------------------------------------------------------
// fba_engine: bitmap store and command execution
// Clears the store after reset, then runs read-modify-write for mark and free,
// a read for test, and a word-by-word walk for find.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_engine
  import fba_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF,
  localparam int AW          = $clog2(BITMAP_WORDS),
  localparam int LW          = $clog2(BITMAP_WORDS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] total_frames,
  input  wire logic             q_valid,
  input  wire q_entry_t         q_head,
  output eng_ctl_t              ctl,
  output logic                  done,
  output result_t               result
);

  localparam int TW = CFG_W - BIT_W;
  localparam int CW = LW + 1;

  state_t            state, state_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic [AW-1:0]     scan_addr, scan_addr_next;
  logic [LW-1:0]     limit, limit_next;
  q_entry_t          cur, cur_next;
  logic              done_next;
  result_t           result_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  logic [TW-1:0]     tf_words;
  logic [LW-1:0]     lim;
  logic [DATA_W-1:0] mask;

  fba_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // search bound in words, clamped to the store
  assign tf_words = total_frames[CFG_W-1:BIT_W];
  assign lim = (tf_words > TW'(BITMAP_WORDS)) ? LW'(BITMAP_WORDS) : LW'(tf_words);
  assign mask = DATA_W'(1) << cur.bit_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    limit     <= limit_next;
    cur       <= cur_next;
    result    <= result_next;
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    scan_addr_next = scan_addr;
    limit_next     = limit;
    cur_next       = cur;
    done_next      = 1'b0;
    result_next    = '0;
    we             = 1'b0;
    waddr          = cur.word[AW-1:0];
    wdata          = rdata;
    raddr          = scan_addr;
    ctl.pop        = 1'b0;
    ctl.clearing   = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        ctl.clearing = 1'b1;
        we           = 1'b1;
        waddr        = clr_addr;
        wdata        = '0;
        if (clr_addr == AW'(BITMAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      ST_IDLE: begin
        if (q_valid) begin
          ctl.pop  = 1'b1;
          cur_next = q_head;
          unique case (q_head.cmd) inside
            CMD_MARK, CMD_FREE, CMD_TEST: begin
              if (q_head.in_range) begin
                raddr      = q_head.word[AW-1:0];
                state_next = ST_RMW;
              end else begin
                done_next = 1'b1;
              end
            end
            CMD_FIND: begin
              if (lim <= LW'(SEARCH_START_WORD)) begin
                done_next             = 1'b1;
                result_next.none_free = 1'b1;
              end else begin
                raddr          = AW'(SEARCH_START_WORD);
                scan_addr_next = AW'(SEARCH_START_WORD);
                limit_next     = lim;
                state_next     = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        case (cur.cmd)
          CMD_MARK: begin
            we    = 1'b1;
            wdata = rdata | mask;
          end
          CMD_FREE: begin
            we    = 1'b1;
            wdata = rdata & ~mask;
          end
          CMD_TEST: result_next.frame_in_use = rdata[cur.bit_sel];
          default: ;
        endcase
      end

      ST_SCAN: begin
        if (rdata != '1) begin
          done_next               = 1'b1;
          result_next.found_frame = {WORD_W'(scan_addr), lowest_zero(rdata)};
          state_next              = ST_IDLE;
        end else if ((CW'(scan_addr) + CW'(1)) >= CW'(limit)) begin
          done_next             = 1'b1;
          result_next.none_free = 1'b1;
          state_next            = ST_IDLE;
        end else begin
          raddr          = scan_addr + AW'(1);
          scan_addr_next = scan_addr + AW'(1);
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/frame_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core: page frame bitmap allocator
// One bit per 4 KiB frame; mark used, mark free, test, find lowest free.
// ----------------------------------------------------------------------------
// After reset the block clears its bitmap RAM one word per cycle, through all
// BITMAP_WORDS words (32768 by default); busy stays high until that is done,
// while total_frames can still be written. A request is taken when start is
// high and busy is low and lands in a two-entry queue, so busy drops again as
// soon as there is room. In the engine, an in-range mark, free or test makes one
// RAM read, then the write-back or answer. Find walks the words from word 8 up
// to the first word with a free bit or to the search bound, one read at a time
// through the single RAM read port. Every request gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it.
`default_nettype none

module frame_bitmap_allocator_core
  import fba_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             start,
  input  wire req_t             request,
  output logic                  busy,
  output logic                  done,
  output result_t               result
);

  logic [CFG_W-1:0] total_frames;
  eng_ctl_t         ctl;
  logic             q_valid;
  q_entry_t         q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= '0;
    end else if (cfg_write) begin
      total_frames <= cfg_data;
    end
  end

  fba_front #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .ctl     (ctl),
    .busy    (busy),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  fba_engine #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .total_frames (total_frames),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .ctl          (ctl),
    .done         (done),
    .result       (result)
  );

endmodule

`default_nettype wire

/* hdl/fba_checker.sv */
// ----------------------------------------------------------------------------
// fba_checker: port-level checks for the frame bitmap allocator
// Watches reset behavior and the consistency of result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_checker
  import fba_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  // the clearing pass holds requests off right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

  a_none_has_no_frame: assert property (@(posedge clk) disable iff (rst)
    (done && result.none_free) |-> (result.found_frame == '0 && !result.frame_in_use))
    else $error("none_free result carries other fields");

  a_test_only_flag: assert property (@(posedge clk) disable iff (rst)
    (done && result.frame_in_use) |-> (result.found_frame == '0))
    else $error("test result carries a frame number");

endmodule

bind frame_bitmap_allocator_core fba_checker u_fba_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

/* test/tb_frame_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_frame_bitmap_allocator_core: self-checking bench for the frame allocator
// Drives mark/free/test/find requests under several frame-count settings,
// tracks its own copy of the frame bitmap and compares every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_frame_bitmap_allocator_core;
  import fba_pkg::*;

  localparam int MAP_WORDS   = BITMAP_WORDS_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;

  class frame_tracker;
    logic [DATA_W-1:0] bitmap [MAP_WORDS];
    logic [CFG_W-1:0]  total_frames;
    result_t           pending[$];
    int                errors;
    int                n_requests;
    int                n_finds;
    int                n_empty;

    function new();
      foreach (bitmap[i]) bitmap[i] = '0;
      total_frames = '0;
      errors       = 0;
      n_requests   = 0;
      n_finds      = 0;
      n_empty      = 0;
    endfunction

    // apply one accepted request to the bitmap copy and queue its result
    function void log_request(req_t r);
      cmd_t               op;
      logic [FRAME_W-1:0] frame;
      int                 word;
      int                 bit_idx;
      int                 bound;
      int                 i;
      int                 n;
      result_t            exp;
      op      = cmd_t'(r.command);
      frame   = r.frame_address[ADDR_W-1:FRAME_SHIFT];
      word    = int'(frame >> BIT_W);
      bit_idx = int'(frame[BIT_W-1:0]);
      exp     = '0;
      n_requests++;
      case (op)
        CMD_MARK: begin
          if (word < MAP_WORDS) bitmap[word][bit_idx] = 1'b1;
        end
        CMD_FREE: begin
          if (word < MAP_WORDS) bitmap[word][bit_idx] = 1'b0;
        end
        CMD_TEST: begin
          if (word < MAP_WORDS) exp.frame_in_use = bitmap[word][bit_idx];
        end
        CMD_FIND: begin
          n_finds++;
          // bound is total_frames/32, clamped to the store size
          bound = int'(total_frames >> BIT_W);
          if (bound > MAP_WORDS) bound = MAP_WORDS;
          exp.none_free = 1'b1;
          i = SEARCH_START_WORD;
          while (exp.none_free && i < bound) begin
            if (bitmap[i] != '1) begin
              n = 0;
              while (bitmap[i][n]) n++;
              exp.found_frame = FRAME_W'(i * DATA_W + n);
              exp.none_free   = 1'b0;
            end
            i++;
          end
          if (exp.none_free) n_empty++;
        end
        default: ;
      endcase
      pending.push_back(exp);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp = pending.pop_front();
        if (got.frame_in_use !== exp.frame_in_use) begin
          $error("frame_in_use: expected %0d, got %0d", exp.frame_in_use, got.frame_in_use);
          errors++;
        end
        if (got.found_frame !== exp.found_frame) begin
          $error("found_frame: expected 0x%05h, got 0x%05h", exp.found_frame, got.found_frame);
          errors++;
        end
        if (got.none_free !== exp.none_free) begin
          $error("none_free: expected %0d, got %0d", exp.none_free, got.none_free);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             start     = 1'b0;
  req_t             request   = '0;
  logic             busy;
  logic             done;
  result_t          result;

  frame_tracker     tracker;
  int unsigned      cycles     = 0;
  int               n_settings = 0;

  frame_bitmap_allocator_core #(
    .BITMAP_WORDS(MAP_WORDS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // start stays high on return so back-to-back requests need no toggle
  task automatic send_request(input cmd_t op, input logic [ADDR_W-1:0] addr);
    req_t r;
    r.command       = op;
    r.frame_address = addr;
    request <= r;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.log_request(r);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_total_frames(input logic [CFG_W-1:0] v);
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.total_frames = v;
    n_settings++;
  endtask

  function automatic logic [ADDR_W-1:0] hot_address(input int word, input int bit_idx);
    return {WORD_W'(word), BIT_W'(bit_idx), 12'($urandom)};
  endfunction

  task automatic random_request(input int hot_span);
    logic [ADDR_W-1:0] addr;
    int                roll;
    cmd_t              op;
    // most traffic lands just above the first MiB so words there fill up
    if ($urandom_range(0, 99) < 60) begin
      addr = hot_address(SEARCH_START_WORD + $urandom_range(0, hot_span - 1),
                         $urandom_range(0, 31));
    end else begin
      addr = $urandom;
    end
    roll = $urandom_range(0, 99);
    if (roll < 45) op = CMD_MARK;
    else if (roll < 60) op = CMD_FREE;
    else if (roll < 80) op = CMD_TEST;
    else op = CMD_FIND;
    send_request(op, addr);
  endtask

  // mark a whole word so the next find has to step past it
  task automatic fill_word(input int word, input bit gaps);
    for (int b = 0; b < DATA_W; b++) begin
      send_request(CMD_MARK, hot_address(word, b));
      if (gaps) idle_for(pick_gap());
    end
    send_request(CMD_FIND, $urandom);
  endtask

  initial begin
    logic [CFG_W-1:0] settings [PHASES];
    int               count;
    int               hot_span;
    bit               gaps;
    tracker = new();
    settings = '{21'h1FFFFF, 21'd288, 21'd1048576, 21'd320,
                 21'd0, 21'd300, 21'd1048575, 21'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset bound of zero: find is empty; top and bottom frames
    send_request(CMD_FIND, 32'h0000_0000);
    send_request(CMD_MARK, 32'hFFFF_FFFF);
    send_request(CMD_TEST, 32'hFFFF_F000);
    send_request(CMD_FREE, 32'hFFFF_FFFF);
    send_request(CMD_TEST, 32'hFFFF_FFFF);
    send_request(CMD_MARK, 32'h0000_0000);
    send_request(CMD_TEST, 32'h0000_0FFF);
    drain();
    // bound above the store is clamped
    write_total_frames(21'h1FFFFF);
    send_request(CMD_FIND, 32'hFFFF_FFFF);
    send_request(CMD_MARK, 32'h0010_0000);
    send_request(CMD_FIND, 32'h0000_0000);
    send_request(CMD_TEST, 32'h0010_0ABC);
    send_request(CMD_FREE, 32'h0010_0000);
    drain();
    // bound of exactly 8 words searches nothing
    write_total_frames(21'd256);
    send_request(CMD_FIND, 32'h0010_0000);
    drain();
    // partly filled last word is left out
    write_total_frames(21'd319);
    send_request(CMD_FIND, 32'h0010_0000);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_total_frames(p == PHASES - 1 ? CFG_W'($urandom_range(0, 21'h1FFFFF)) : settings[p]);
      gaps     = (p % 3 != 2);
      hot_span = 1 + p % 4;
      count    = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 3) begin
          fill_word(SEARCH_START_WORD + $urandom_range(0, 3), gaps);
          count += DATA_W + 1;
        end else begin
          random_request(hot_span);
          count++;
        end
        if ($urandom_range(0, 199) == 0) drain();
        else if (gaps) idle_for(pick_gap());
      end
    end
    drain();

    $display("Ran %0d requests under %0d frame-count settings", tracker.n_requests, n_settings);
    $display("%0d searches, %0d of them found no free frame", tracker.n_finds, tracker.n_empty);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
